>>> src/lsbp_pkg.sv
// Shared types, constants and helpers for the LSB-first bit packer.
`default_nettype none

package lsbp_pkg;

  // Field and state widths
  localparam int AccBits  = 64;
  localparam int HeldBits = 7;
  localparam int OffBits  = 19;
  localparam int OutAddrW = 16;
  localparam int WinBits  = AccBits + 8;

  // Address wrap width; the output port is always 16 bits wide
  localparam int AddrBits = 16;
  localparam logic [OutAddrW-1:0] AddrMask =
    (AddrBits >= OutAddrW) ? {OutAddrW{1'b1}} : OutAddrW'((1 << AddrBits) - 1);

  // Command codes
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // One pending flush: held bits, their count and the bit offset they go to
  typedef struct packed {
    logic [AccBits-1:0]  acc;
    logic [HeldBits-1:0] held;
    logic [OffBits-1:0]  offset;
  } flush_t;

  // Mask of the low n bits, n in 0..64 (bit 6 set means all ones)
  function automatic logic [AccBits-1:0] low_mask(input logic [HeldBits-1:0] n);
    logic [AccBits-1:0] m;
    if (n[6]) begin
      m = {AccBits{1'b1}};
    end else begin
      m = (AccBits'(1) << n[5:0]) - AccBits'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> src/lsbp_in_if.sv
// Input channel of the bit packer: command, field value and field length.
`default_nettype none

interface lsbp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] bits;
  logic [6:0]  field_len;

  modport source (output valid, output cmd, output bits, output field_len, input ready);
  modport sink   (input valid, input cmd, input bits, input field_len, output ready);
endinterface

`default_nettype wire

>>> src/lsbp_out_if.sv
// Output channel of the bit packer: one masked byte write per transaction.
`default_nettype none

interface lsbp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] byte_addr;
  logic [7:0]  byte_data;
  logic [7:0]  bit_mask;
  logic        last;

  modport source (output valid, output byte_addr, output byte_data, output bit_mask,
                  output last, input ready);
  modport sink   (input valid, input byte_addr, input byte_data, input bit_mask,
                  input last, output ready);
endinterface

`default_nettype wire

>>> src/lsbp_front.sv
// Front end: takes pushes into the accumulator and hands flushes to the queue.
`default_nettype none

module lsbp_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lsbp_pkg::OffBits-1:0] cfg_wdata_i,
  lsbp_in_if.sink                           in_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output lsbp_pkg::flush_t                  q_data_o
);

  logic [lsbp_pkg::AccBits-1:0]  acc_q, acc_d;
  logic [lsbp_pkg::HeldBits-1:0] held_q, held_d;
  logic [lsbp_pkg::OffBits-1:0]  off_q, off_d;

  logic                          accept;
  logic [lsbp_pkg::HeldBits-1:0] n_sat;
  logic [lsbp_pkg::HeldBits:0]   held_sum;
  logic [lsbp_pkg::AccBits-1:0]  field;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Long fields count as 64 bits
  assign n_sat    = in_i.field_len[6] ? lsbp_pkg::HeldBits'(64) : in_i.field_len;
  assign held_sum = {1'b0, held_q} + {1'b0, n_sat};
  assign field    = in_i.bits & lsbp_pkg::low_mask(n_sat);

  // An empty flush is dropped here and never reaches the queue
  assign q_push_o = accept && (in_i.cmd == lsbp_pkg::CMD_FLUSH) && (held_q != '0);
  assign q_data_o = '{acc: acc_q, held: held_q, offset: off_q};

  // Accumulator, fill count and running offset
  always_comb begin
    acc_d  = acc_q;
    held_d = held_q;
    off_d  = off_q;
    if (cfg_we_i) begin
      off_d = cfg_wdata_i;
    end else if (accept && in_i.cmd == lsbp_pkg::CMD_PUSH) begin
      // bits past position 63 fall off the shift
      if (!held_q[6]) begin
        acc_d = acc_q | (field << held_q[5:0]);
      end
      held_d = (held_sum > (lsbp_pkg::HeldBits + 1)'(64)) ?
               lsbp_pkg::HeldBits'(64) : held_sum[lsbp_pkg::HeldBits-1:0];
    end else if (q_push_o) begin
      acc_d  = '0;
      held_d = '0;
      off_d  = off_q + lsbp_pkg::OffBits'(held_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
      off_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      held_q <= held_d;
      off_q  <= off_d;
    end
  end

endmodule

`default_nettype wire

>>> src/lsbp_fifo.sv
// Two-entry queue of pending flushes between front and back end.
`default_nettype none

module lsbp_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lsbp_pkg::flush_t push_data_i,
  input  wire logic             pop_i,
  output lsbp_pkg::flush_t      pop_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  lsbp_pkg::flush_t entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o     = count_q[1];
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/lsbp_back.sv
// Back end: turns one queued flush into a run of masked byte writes.
`default_nettype none

module lsbp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lsbp_pkg::flush_t q_data_i,
  input  wire logic             q_empty_i,
  output logic                  q_pop_o,
  lsbp_out_if.source            out_o
);

  logic [lsbp_pkg::WinBits-1:0]  data_q, data_d;
  logic [lsbp_pkg::WinBits-1:0]  mask_q, mask_d;
  logic [lsbp_pkg::OutAddrW-1:0] addr_q, addr_d;
  logic                          busy_q, busy_d;

  logic                          out_acc;
  logic                          is_last;
  logic [2:0]                    sub_off;

  // Final byte: nothing left in the mask above it
  assign is_last = (mask_q[lsbp_pkg::WinBits-1:8] == '0);
  assign out_acc = out_o.valid && out_o.ready;
  assign q_pop_o = !q_empty_i && (!busy_q || (out_acc && is_last));
  assign sub_off = q_data_i.offset[2:0];

  assign out_o.valid     = busy_q;
  assign out_o.byte_addr = addr_q;
  assign out_o.byte_data = data_q[7:0] & mask_q[7:0];
  assign out_o.bit_mask  = mask_q[7:0];
  assign out_o.last      = is_last;

  // Load a new window on pop, step one byte per accepted transaction
  always_comb begin
    data_d = data_q;
    mask_d = mask_q;
    addr_d = addr_q;
    busy_d = busy_q;
    if (q_pop_o) begin
      data_d = lsbp_pkg::WinBits'(q_data_i.acc) << sub_off;
      mask_d = lsbp_pkg::WinBits'(lsbp_pkg::low_mask(q_data_i.held)) << sub_off;
      addr_d = q_data_i.offset[lsbp_pkg::OffBits-1:3] & lsbp_pkg::AddrMask;
      busy_d = 1'b1;
    end else if (out_acc) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        data_d = data_q >> 8;
        mask_d = mask_q >> 8;
        addr_d = (addr_q + lsbp_pkg::OutAddrW'(1)) & lsbp_pkg::AddrMask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    mask_q <= mask_d;
    addr_q <= addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

endmodule

`default_nettype wire

>>> src/lsb_first_bit_packer.sv
// LSB-first bit packer: pushes fill a 64-bit accumulator at one transaction
// per clock unless the input stalls; a flush is accepted and queued, and its
// byte writes (one per memory byte touched, up to nine, the last one flagged)
// leave one per clock while the output is ready. The input stalls only while
// two flushes are waiting behind the one being written out, so the two-entry
// flush queue and the one-byte-per-clock write stage set the rate.
`default_nettype none

module lsb_first_bit_packer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lsbp_pkg::OffBits-1:0] cfg_wdata_i,
  lsbp_in_if.sink                           in_i,
  lsbp_out_if.source                        out_o
);

  logic             q_push, q_pop, q_full, q_empty;
  lsbp_pkg::flush_t q_wdata, q_rdata;

  lsbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  lsbp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  lsbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (q_rdata),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // Every write touches at least one bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.bit_mask != 8'd0)
    else $error("byte write with empty mask");

  // Bits are contiguous: a write that is not the last runs up to bit 7
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> out_o.bit_mask[7])
    else $error("gap in bit mask before last write");

  // Writes within one flush go to consecutive byte addresses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=>
      (out_o.valid && out_o.byte_addr ==
       (($past(out_o.byte_addr) + 16'd1) & lsbp_pkg::AddrMask)))
    else $error("byte address did not advance within a flush");

  // A queued flush is never taken from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty flush queue");

endmodule

`default_nettype wire
